// ===== hw/rtl/stok_pkg.sv =====
// Package: shared types, codes and the keyword lookup of the source tokenizer.
`default_nettype none
package stok_pkg;

    localparam int KIND_W = 6;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_SLASH   = 4'd1,
        M_COMMENT = 4'd2,
        M_IDENT   = 4'd3,
        M_NUMBER  = 4'd4,
        M_QUOTE1  = 4'd5,
        M_QUOTE2  = 4'd6,
        M_STR     = 4'd7,
        M_STR_ESC = 4'd8,
        M_TRIPLE  = 4'd9,
        M_EQ      = 4'd10,
        M_BANG    = 4'd11,
        M_LT      = 4'd12,
        M_GT      = 4'd13
    } t_mode;

    localparam logic [KIND_W-1:0] K_EOF     = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT   = 6'd1;
    localparam logic [KIND_W-1:0] K_NUMBER  = 6'd21;
    localparam logic [KIND_W-1:0] K_STRING  = 6'd22;
    localparam logic [KIND_W-1:0] K_EQ      = 6'd23;
    localparam logic [KIND_W-1:0] K_NEQ     = 6'd24;
    localparam logic [KIND_W-1:0] K_LTE     = 6'd25;
    localparam logic [KIND_W-1:0] K_GTE     = 6'd26;
    localparam logic [KIND_W-1:0] K_LT      = 6'd27;
    localparam logic [KIND_W-1:0] K_GT      = 6'd28;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd29;
    localparam logic [KIND_W-1:0] K_SLASH   = 6'd43;
    localparam logic [KIND_W-1:0] K_UNKNOWN = 6'd45;

    // Classified input word, front to back.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_end;
        logic       is_space;
        logic       is_digit;
        logic       is_wstart;
        logic [KIND_W-1:0] single_kind;
        logic       is_single;
    } t_cls;

    // One pending token request, kind resolved later.
    typedef struct packed {
        logic              valid;
        logic              is_word;
        logic [KIND_W-1:0] kind;
        logic [1:0]        start_sel; // lexeme start, position, or fixed len
    } t_req;

    function automatic logic [KIND_W-1:0] single_lookup(input logic [7:0] b);
        case (b)
            8'h3A: single_lookup = 6'd30;
            8'h2C: single_lookup = 6'd31;
            8'h3B: single_lookup = 6'd32;
            8'h2E: single_lookup = 6'd33;
            8'h5B: single_lookup = 6'd34;
            8'h5D: single_lookup = 6'd35;
            8'h7B: single_lookup = 6'd36;
            8'h7D: single_lookup = 6'd37;
            8'h28: single_lookup = 6'd38;
            8'h29: single_lookup = 6'd39;
            8'h2B: single_lookup = 6'd40;
            8'h2D: single_lookup = 6'd41;
            8'h2A: single_lookup = 6'd42;
            8'h25: single_lookup = 6'd44;
            default: single_lookup = K_UNKNOWN;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] word_lookup(input logic [63:0] buf_v,
                                                      input logic [3:0] len);
        logic [KIND_W-1:0] k;
        k = K_IDENT;
        case (len)
            4'd2: if (buf_v[15:0] == "if") k = 6'd14;
                  else if (buf_v[15:0] == "or") k = 6'd11;
            4'd3: case (buf_v[23:0])
                      "int": k = 6'd5;
                      "any": k = 6'd9;
                      "and": k = 6'd10;
                      "not": k = 6'd12;
                      "var": k = 6'd13;
                      "for": k = 6'd16;
                      default: k = K_IDENT;
                  endcase
            4'd4: case (buf_v[31:0])
                      "case": k = 6'd2;
                      "true": k = 6'd3;
                      "null": k = 6'd4;
                      "bool": k = 6'd8;
                      "else": k = 6'd15;
                      default: k = K_IDENT;
                  endcase
            4'd5: case (buf_v[39:0])
                      "false": k = 6'd3;
                      "float": k = 6'd6;
                      "while": k = 6'd17;
                      "print": k = 6'd19;
                      default: k = K_IDENT;
                  endcase
            4'd6: case (buf_v[47:0])
                      "switch": k = 6'd2;
                      "string": k = 6'd7;
                      "return": k = 6'd20;
                      default: k = K_IDENT;
                  endcase
            4'd7: if (buf_v[55:0] == "default") k = 6'd2;
            4'd8: if (buf_v == "function") k = 6'd18;
            default: k = K_IDENT;
        endcase
        word_lookup = k;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/stok_if.sv =====
// Interfaces: input byte channel and token channel.
`default_nettype none
interface stok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_source;
    modport source (output valid, source_byte, end_of_source, input ready);
    modport sink   (input valid, source_byte, end_of_source, output ready);
endinterface

interface stok_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        last_of_run;
    logic        offset_overflow;
    modport source (output valid, token_kind, token_start, token_length, last_of_run,
                    offset_overflow, input ready);
    modport sink   (input valid, token_kind, token_start, token_length, last_of_run,
                    offset_overflow, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/source_tokenizer.sv =====
// Top level of the streaming source tokenizer.
// Usage:
//  - in_ch: one source byte word per handshake (valid/ready), with an end flag.
//    A zero byte or the end flag closes the source: any pending token, then EOF.
//  - out_ch: token words {kind, start, length, last_of_run, offset_overflow}.
//    last_of_run marks the final token caused by one input word.
//  - Throughput: one input word per cycle while the queue has room for two
//    words; each word yields zero to two tokens, registered into the queue.
//  - The front scanner writes into a four-word token queue; input is taken
//    whenever the queue has room for two words, so a stalled receiver only
//    stalls input once the queue fills. A ready out_ch drains one word a cycle.
//  - Reset (i_rst_n low, synchronous) returns the scanner to idle, position 0,
//    and empties the queue.
//  - Offsets count bytes from the source start and saturate at the top of the
//    OFFSET_BITS range, raising offset_overflow until the source ends.
`default_nettype none
module source_tokenizer #(
    parameter int OFFSET_BITS = 32
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    stok_in_if.sink    in_ch,
    stok_out_if.source out_ch
);
    import stok_pkg::*;

    logic        room, fr_ready;
    logic [1:0]  cnt;
    logic [70:0] tok0, tok1;
    logic [71:0] word;

    stok_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid (in_ch.valid),
        .i_byte  (in_ch.source_byte),
        .i_end   (in_ch.end_of_source),
        .i_ready (room),
        .o_ready (fr_ready),
        .o_cnt   (cnt),
        .o_tok0  (tok0),
        .o_tok1  (tok1)
    );

    stok_queue u_queue (
        .i_clk, .i_rst_n,
        .i_cnt   (cnt),
        .i_tok0  (tok0),
        .i_tok1  (tok1),
        .o_room  (room),
        .o_valid (out_ch.valid),
        .i_ready (out_ch.ready),
        .o_word  (word)
    );

    assign in_ch.ready            = fr_ready;
    assign out_ch.last_of_run     = word[71];
    assign out_ch.offset_overflow = word[70];
    assign out_ch.token_kind      = word[69:64];
    assign out_ch.token_start     = word[63:32];
    assign out_ch.token_length    = word[31:0];

    // An ending word always yields at least the EOF token.
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready && in_ch.end_of_source) |-> (cnt != 2'd0))
        else $error("end of source produced no token");
    // Tokens are only produced when the queue has room for two words.
    a_no_ovr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cnt != 2'd0) |-> room)
        else $error("token queue overrun");
    // Token kinds never exceed unknown.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (out_ch.token_kind <= K_UNKNOWN))
        else $error("bad token kind");
endmodule
`default_nettype wire

// ===== hw/rtl/stok_front.sv =====
// Front: scanner state machine, emits up to two token words per byte.
`default_nettype none
module stok_front #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_end,
    input  wire logic        i_ready,   // queue has room for two words
    output logic             o_ready,
    output logic [1:0]       o_cnt,
    output logic [70:0]      o_tok0,    // {ovf, kind, start, len}
    output logic [70:0]      o_tok1
);
    import stok_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] LEN1    = OFFSET_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] LEN2    = OFFSET_BITS'(2);

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_pos, n_pos, r_lex, n_lex;
    logic [63:0]            r_kbuf, n_kbuf;
    logic [3:0]             r_ilen, n_ilen;
    logic                   r_dot, n_dot;
    logic [1:0]             r_qrun, n_qrun;
    logic                   r_ovf, n_ovf;

    logic                   fire, isend, sp, dg, ws, wc;
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] pnext, pm2;
    logic [KIND_W-1:0]      wkind;
    logic [1:0]             cnt;
    logic [KIND_W-1:0]      k0, k1;
    logic [OFFSET_BITS-1:0] s0, s1, l0, l1;
    logic                   idle_go;

    assign o_ready = i_ready;
    assign fire    = i_valid && i_ready;
    assign b       = i_byte;
    assign isend   = i_end || (b == 8'd0);
    assign sp      = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
    assign dg      = (b >= "0") && (b <= "9");
    assign ws      = (((b | 8'h20) >= "a") && ((b | 8'h20) <= "z")) || (b == "_");
    assign wc      = ws || dg;
    assign pnext   = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign pm2     = (r_pos >= OFFSET_BITS'(2)) ? r_pos - OFFSET_BITS'(2) : '0;
    assign wkind   = (r_ilen > 4'd8) ? K_IDENT : word_lookup(r_kbuf, r_ilen);

    function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] f,
                                                    input logic [OFFSET_BITS-1:0] t);
        span = (t >= f) ? t - f : '0;
    endfunction

    always_comb begin
        n_mode = r_mode; n_pos = r_pos; n_lex = r_lex; n_kbuf = r_kbuf;
        n_ilen = r_ilen; n_dot = r_dot; n_qrun = r_qrun; n_ovf = r_ovf;
        cnt = 2'd0; k0 = K_EOF; k1 = K_EOF;
        s0 = r_pos; s1 = r_pos; l0 = '0; l1 = '0;
        idle_go = 1'b0;
        if (isend) begin
            cnt = 2'd1;
            k0 = K_EOF; s0 = r_pos; l0 = '0;
            case (r_mode)
                M_SLASH:  begin cnt = 2'd2; k0 = K_SLASH; s0 = r_lex; l0 = LEN1; end
                M_IDENT:  begin cnt = 2'd2; k0 = wkind; s0 = r_lex; l0 = span(r_lex, r_pos); end
                M_NUMBER: begin cnt = 2'd2; k0 = K_NUMBER; s0 = r_lex; l0 = span(r_lex, r_pos); end
                M_QUOTE2: begin cnt = 2'd2; k0 = K_STRING; s0 = r_lex; l0 = '0; end
                M_QUOTE1, M_STR, M_STR_ESC, M_TRIPLE: begin
                    cnt = 2'd2; k0 = K_STRING; s0 = r_lex; l0 = span(r_lex, r_pos);
                end
                M_EQ:   begin cnt = 2'd2; k0 = K_ASSIGN; s0 = r_lex; l0 = LEN1; end
                M_BANG: begin cnt = 2'd2; k0 = K_UNKNOWN; s0 = r_lex; l0 = LEN1; end
                M_LT:   begin cnt = 2'd2; k0 = K_LT; s0 = r_lex; l0 = LEN1; end
                M_GT:   begin cnt = 2'd2; k0 = K_GT; s0 = r_lex; l0 = LEN1; end
                default: ;
            endcase
            if (cnt == 2'd2) begin k1 = K_EOF; s1 = r_pos; l1 = '0; end
            n_mode = M_IDLE; n_pos = '0; n_lex = '0; n_kbuf = '0;
            n_ilen = '0; n_dot = 1'b0; n_qrun = '0; n_ovf = 1'b0;
        end else begin
            case (r_mode)
                M_SLASH: if (b == "/") n_mode = M_COMMENT;
                         else begin cnt = 2'd1; k0 = K_SLASH; s0 = r_lex; l0 = LEN1; idle_go = 1'b1; end
                M_COMMENT: if (b == 8'h0A) n_mode = M_IDLE;
                M_IDENT: if (wc) begin
                        if (r_ilen < 4'd8) n_kbuf = {r_kbuf[55:0], b};
                        if (r_ilen < 4'd9) n_ilen = r_ilen + 1'b1;
                    end else begin
                        cnt = 2'd1; k0 = wkind; s0 = r_lex; l0 = span(r_lex, r_pos);
                        idle_go = 1'b1;
                    end
                M_NUMBER: if (dg) ;
                    else if (b == "." && !r_dot) n_dot = 1'b1;
                    else begin
                        cnt = 2'd1; k0 = K_NUMBER; s0 = r_lex; l0 = span(r_lex, r_pos);
                        idle_go = 1'b1;
                    end
                M_QUOTE1: n_mode = (b == 8'h22) ? M_QUOTE2 : ((b == 8'h5C) ? M_STR_ESC : M_STR);
                M_QUOTE2: if (b == 8'h22) begin
                        n_mode = M_TRIPLE; n_lex = pnext; n_qrun = '0;
                    end else begin
                        cnt = 2'd1; k0 = K_STRING; s0 = r_lex; l0 = '0; idle_go = 1'b1;
                    end
                M_STR: if (b == 8'h22) begin
                        cnt = 2'd1; k0 = K_STRING; s0 = r_lex; l0 = span(r_lex, r_pos);
                        n_mode = M_IDLE;
                    end else if (b == 8'h5C) n_mode = M_STR_ESC;
                M_STR_ESC: n_mode = M_STR;
                M_TRIPLE: if (b == 8'h22) begin
                        n_qrun = r_qrun + 1'b1;
                        if (r_qrun == 2'd2) begin
                            cnt = 2'd1; k0 = K_STRING; s0 = r_lex; l0 = span(r_lex, pm2);
                            n_qrun = '0; n_mode = M_IDLE;
                        end
                    end else n_qrun = '0;
                M_EQ, M_BANG, M_LT, M_GT: begin
                    cnt = 2'd1; s0 = r_lex;
                    if (b == "=") begin
                        l0 = LEN2; n_mode = M_IDLE;
                        case (r_mode)
                            M_EQ: k0 = K_EQ;
                            M_BANG: k0 = K_NEQ;
                            M_LT: k0 = K_LTE;
                            default: k0 = K_GTE;
                        endcase
                    end else begin
                        l0 = LEN1; idle_go = 1'b1;
                        case (r_mode)
                            M_EQ: k0 = K_ASSIGN;
                            M_BANG: k0 = K_UNKNOWN;
                            M_LT: k0 = K_LT;
                            default: k0 = K_GT;
                        endcase
                    end
                end
                default: idle_go = 1'b1;
            endcase
            if (idle_go) begin
                n_mode = M_IDLE; n_lex = r_pos;
                if (sp) ;
                else if (ws) begin n_mode = M_IDENT; n_kbuf = {56'd0, b}; n_ilen = 4'd1; end
                else if (dg) begin n_mode = M_NUMBER; n_dot = 1'b0; end
                else begin
                    case (b)
                        "/": n_mode = M_SLASH;
                        8'h22: begin n_mode = M_QUOTE1; n_lex = pnext; end
                        "=": n_mode = M_EQ;
                        "!": n_mode = M_BANG;
                        "<": n_mode = M_LT;
                        ">": n_mode = M_GT;
                        default: begin
                            if (cnt == 2'd0) begin
                                k0 = single_lookup(b); s0 = r_pos; l0 = LEN1;
                            end else begin
                                k1 = single_lookup(b); s1 = r_pos; l1 = LEN1;
                            end
                            cnt = cnt + 1'b1;
                        end
                    endcase
                end
            end
            if (r_pos == POS_MAX) n_ovf = 1'b1;
            n_pos = pnext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_pos <= '0; r_lex <= '0; r_kbuf <= '0;
            r_ilen <= '0; r_dot <= 1'b0; r_qrun <= '0; r_ovf <= 1'b0;
        end else if (fire) begin
            r_mode <= n_mode; r_pos <= n_pos; r_lex <= n_lex; r_kbuf <= n_kbuf;
            r_ilen <= n_ilen; r_dot <= n_dot; r_qrun <= n_qrun; r_ovf <= n_ovf;
        end
    end

    assign o_cnt  = fire ? cnt : 2'd0;
    assign o_tok0 = {r_ovf, k0, 32'(s0), 32'(l0)};
    assign o_tok1 = {r_ovf, k1, 32'(s1), 32'(l1)};
endmodule
`default_nettype wire

// ===== hw/rtl/stok_queue.sv =====
// Token queue: takes up to two words per cycle, delivers one when i_ready is high.
`default_nettype none
module stok_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [1:0]  i_cnt,
    input  wire logic [70:0] i_tok0,
    input  wire logic [70:0] i_tok1,
    output logic             o_room,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [71:0]      o_word   // {last, ovf, kind, start, len}
);
    localparam int DEPTH = 4;
    logic [71:0] r_mem [DEPTH];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt, n_cnt;
    logic        pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_word  = r_mem[r_rp];
    assign o_room  = (r_cnt <= 3'd2);
    assign n_cnt   = r_cnt + {1'b0, i_cnt} - {2'b0, pop};

    always_ff @(posedge i_clk) begin
        if (i_cnt != 2'd0) begin
            r_mem[r_wp] <= {(i_cnt == 2'd1), i_tok0};
            if (i_cnt == 2'd2) r_mem[r_wp + 2'd1] <= {1'b1, i_tok1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_cnt;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire
